// ===== rtl/core/rpes_pkg.sv =====
// Package for the RTP payload equal splitter: widths, reset values,
// status codes, state type and the controller/datapath command and status bundles.
// No dependencies.
package rpes_pkg;

   localparam int PAYLOAD_WIDTH   = 20;
   localparam int CFG_WIDTH       = 16;
   localparam int TOTAL_WIDTH     = 21;  // payload plus both reductions
   localparam int NUMER_WIDTH     = 22;  // total plus max_payload minus one
   localparam int CSR_INDEX_WIDTH = 2;

   localparam int DEFAULT_MAX_PACKETS = 64;

   localparam logic [CFG_WIDTH-1:0] MAX_PAYLOAD_RESET      = 16'd1200;
   localparam logic [CFG_WIDTH-1:0] FIRST_REDUCTION_RESET  = 16'd0;
   localparam logic [CFG_WIDTH-1:0] LAST_REDUCTION_RESET   = 16'd0;
   localparam logic [CFG_WIDTH-1:0] SINGLE_REDUCTION_RESET = 16'd0;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_PAYLOAD      = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIRST_REDUCTION  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LAST_REDUCTION   = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SINGLE_REDUCTION = 2'd3;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_EMPTY = 3'd1,
      ST_NEG   = 3'd2,
      ST_NOCAP = 3'd3,
      ST_FEW   = 3'd4,
      ST_MANY  = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_DIV_COUNT,
      S_CHECK_COUNT,
      S_DIV_SPLIT,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic load;         // capture payload of the accepted beat
      logic early_emit;   // emit single result from the first checks
      logic div_start;    // launch the shared divider
      logic div_split;    // 0: packet count division, 1: per-packet division
      logic latch_num;    // capture packet count
      logic late_emit;    // emit too-few or too-many status
      logic latch_split;  // capture per, larger and loop counters
      logic step;         // emit one packet size
   } cmd_type;

   typedef struct packed {
      logic early_hit;
      logic div_done;
      logic count_bad;
      logic step_last;
   } stat_type;

endpackage

// ===== rtl/core/rpes_divider.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Depends on rpes_pkg for its default widths; standalone otherwise.
module rpes_divider import rpes_pkg::*; #(
   parameter int DIVIDEND_WIDTH = NUMER_WIDTH,
   parameter int DIVISOR_WIDTH  = CFG_WIDTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [DIVIDEND_WIDTH-1:0] dividend,
   input  logic [DIVISOR_WIDTH-1:0]  divisor,
   output logic                      done,
   output logic [DIVIDEND_WIDTH-1:0] quotient,
   output logic [DIVISOR_WIDTH-1:0]  remainder
);

   localparam int CNT_WIDTH = $clog2(DIVIDEND_WIDTH + 1);

   logic [DIVIDEND_WIDTH-1:0] quo_ff, quo_in;
   logic [DIVISOR_WIDTH-1:0]  rem_ff, rem_in;
   logic [DIVISOR_WIDTH-1:0]  div_ff, div_in;
   logic [CNT_WIDTH-1:0]      cnt_ff, cnt_in;
   logic                      run_ff, run_in;
   logic                      done_ff, done_in;
   logic [DIVISOR_WIDTH:0]    trial;
   logic [DIVISOR_WIDTH:0]    diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIVIDEND_WIDTH-1]};
      diff    = trial - {1'b0, div_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         div_in = divisor;
         cnt_in = CNT_WIDTH'(DIVIDEND_WIDTH);
         run_in = 1'b1;
      end else if (run_ff) begin
         // shift in the next dividend bit, subtract when it fits
         if (trial >= {1'b0, div_ff}) begin
            rem_in = diff[DIVISOR_WIDTH-1:0];
            quo_in = {quo_ff[DIVIDEND_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVISOR_WIDTH-1:0];
            quo_in = {quo_ff[DIVIDEND_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_WIDTH'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/core/rpes_datapath.sv =====
// Datapath: configuration registers, early checks, shared divider, packet loop
// registers and the result registers. Depends on rpes_pkg and rpes_divider.
module rpes_datapath import rpes_pkg::*; #(
   parameter int MAX_PACKETS = DEFAULT_MAX_PACKETS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   output stat_type                   stat,
   input  logic [PAYLOAD_WIDTH-1:0]   req_payload_size,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]       csr_write_data,
   output logic                       rsp_strobe,
   output logic [PAYLOAD_WIDTH-1:0]   rsp_packet_bytes,
   output logic                       rsp_last_packet,
   output logic [2:0]                 rsp_status
);

   localparam int CNT_WIDTH = $clog2(MAX_PACKETS + 1);

   logic [CFG_WIDTH-1:0]     max_payload_ff, first_red_ff, last_red_ff, single_red_ff;
   logic [PAYLOAD_WIDTH-1:0] payload_ff;
   logic [NUMER_WIDTH-1:0]   num_ff;
   logic [TOTAL_WIDTH-1:0]   per_ff, per_in;
   logic [CNT_WIDTH-1:0]     larger_ff, left_ff, left_in;
   logic [PAYLOAD_WIDTH-1:0] remaining_ff, remaining_in;
   logic                     first_ff;

   logic                     rsp_strobe_ff, rsp_strobe_in;
   logic [PAYLOAD_WIDTH-1:0] rsp_bytes_ff, rsp_bytes_in;
   logic                     rsp_last_ff, rsp_last_in;
   status_type               rsp_status_ff, rsp_status_in;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MAX_PAYLOAD_RESET;
         first_red_ff   <= FIRST_REDUCTION_RESET;
         last_red_ff    <= LAST_REDUCTION_RESET;
         single_red_ff  <= SINGLE_REDUCTION_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MAX_PAYLOAD:      max_payload_ff <= csr_write_data;
            CSR_FIRST_REDUCTION:  first_red_ff   <= csr_write_data;
            CSR_LAST_REDUCTION:   last_red_ff    <= csr_write_data;
            CSR_SINGLE_REDUCTION: single_red_ff  <= csr_write_data;
         endcase
      end
   end

   // early checks, in priority order
   logic [TOTAL_WIDTH-1:0] fr_ext, lr_ext, maxp_ext, total;
   logic [NUMER_WIDTH-1:0] numer;
   logic                   fits, nocap;
   status_type             early_code;
   logic                   early_hit;

   always_comb begin
      fr_ext   = TOTAL_WIDTH'(first_red_ff[CFG_WIDTH-2:0]);
      lr_ext   = TOTAL_WIDTH'(last_red_ff[CFG_WIDTH-2:0]);
      maxp_ext = TOTAL_WIDTH'(max_payload_ff);
      total    = TOTAL_WIDTH'(payload_ff) + fr_ext + lr_ext;
      numer    = NUMER_WIDTH'(total) + NUMER_WIDTH'(max_payload_ff) - NUMER_WIDTH'(1);
      fits     = maxp_ext >= (TOTAL_WIDTH'(single_red_ff) + TOTAL_WIDTH'(payload_ff));
      nocap    = (maxp_ext <= fr_ext) || (maxp_ext <= lr_ext);
      early_hit  = 1'b1;
      early_code = ST_OK;
      if (payload_ff == '0) begin
         early_code = ST_EMPTY;
      end else if (first_red_ff[CFG_WIDTH-1] || last_red_ff[CFG_WIDTH-1]) begin
         early_code = ST_NEG;
      end else if (fits) begin
         early_code = ST_OK;
      end else if (nocap) begin
         early_code = ST_NOCAP;
      end else begin
         early_hit = 1'b0;
      end
   end

   // shared divider: packet count first, then the per-packet split
   logic [NUMER_WIDTH-1:0] div_dividend, div_quotient;
   logic [CFG_WIDTH-1:0]   div_divisor, div_remainder;
   logic                   div_done;

   assign div_dividend = cmd.div_split ? NUMER_WIDTH'(total) : numer;
   assign div_divisor  = cmd.div_split ? num_ff[CFG_WIDTH-1:0] : max_payload_ff;

   rpes_divider #(
      .DIVIDEND_WIDTH (NUMER_WIDTH),
      .DIVISOR_WIDTH  (CFG_WIDTH)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   logic few, many;
   assign few  = NUMER_WIDTH'(payload_ff) < num_ff;
   assign many = num_ff > NUMER_WIDTH'(MAX_PACKETS);

   // one packet size per step
   logic [TOTAL_WIDTH-1:0] per_eff, cur_a, cur_b, cur_c, cur, rem_ext;
   logic                   step_last;

   always_comb begin
      rem_ext = TOTAL_WIDTH'(remaining_ff);
      per_eff = (left_ff == larger_ff) ? per_ff + 1'b1 : per_ff;
      if (first_ff) begin
         cur_a = (per_eff > fr_ext + 1'b1) ? per_eff - fr_ext : TOTAL_WIDTH'(1);
      end else begin
         cur_a = per_eff;
      end
      cur_b = (cur_a > rem_ext) ? rem_ext : cur_a;
      // keep at least one byte for the last packet
      cur_c = ((left_ff == CNT_WIDTH'(2)) && (cur_b == rem_ext)) ? cur_b - 1'b1 : cur_b;
      cur   = (left_ff == CNT_WIDTH'(1)) ? rem_ext : cur_c;
      remaining_in = remaining_ff - cur[PAYLOAD_WIDTH-1:0];
      left_in      = left_ff - 1'b1;
      per_in       = per_eff;
      step_last    = (remaining_in == '0) || (left_in == '0);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         payload_ff <= req_payload_size;
      end
      if (cmd.latch_num) begin
         // a frame that needs splitting takes at least two packets
         num_ff <= (div_quotient == NUMER_WIDTH'(1)) ? NUMER_WIDTH'(2) : div_quotient;
      end
      if (cmd.latch_split) begin
         per_ff       <= div_quotient[TOTAL_WIDTH-1:0];
         larger_ff    <= div_remainder[CNT_WIDTH-1:0];
         left_ff      <= num_ff[CNT_WIDTH-1:0];
         remaining_ff <= payload_ff;
         first_ff     <= 1'b1;
      end else if (cmd.step) begin
         per_ff       <= per_in;
         left_ff      <= left_in;
         remaining_ff <= remaining_in;
         first_ff     <= 1'b0;
      end
   end

   // result registers: one beat per strobe
   always_comb begin
      rsp_strobe_in = cmd.early_emit || cmd.late_emit || cmd.step;
      rsp_bytes_in  = '0;
      rsp_last_in   = 1'b1;
      rsp_status_in = ST_OK;
      if (cmd.early_emit) begin
         rsp_status_in = early_code;
         rsp_bytes_in  = (early_code == ST_OK) ? payload_ff : '0;
      end else if (cmd.late_emit) begin
         rsp_status_in = few ? ST_FEW : ST_MANY;
      end else if (cmd.step) begin
         rsp_bytes_in = cur[PAYLOAD_WIDTH-1:0];
         rsp_last_in  = step_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_bytes_ff  <= rsp_bytes_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign stat.early_hit = early_hit;
   assign stat.div_done  = div_done;
   assign stat.count_bad = few || many;
   assign stat.step_last = step_last;

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_packet_bytes = rsp_bytes_ff;
   assign rsp_last_packet  = rsp_last_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

// ===== rtl/core/rpes_ctrl.sv =====
// Controller state machine: sequences checks, the two divisions and the packet loop.
// Depends on rpes_pkg.
module rpes_ctrl import rpes_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.early_hit) begin
               cmd.early_emit = 1'b1;
               state_in       = S_IDLE;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV_COUNT;
            end
         end
         S_DIV_COUNT: begin
            if (stat.div_done) begin
               cmd.latch_num = 1'b1;
               state_in      = S_CHECK_COUNT;
            end
         end
         S_CHECK_COUNT: begin
            cmd.div_split = 1'b1;
            if (stat.count_bad) begin
               cmd.late_emit = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV_SPLIT;
            end
         end
         S_DIV_SPLIT: begin
            cmd.div_split = 1'b1;
            if (stat.div_done) begin
               cmd.latch_split = 1'b1;
               state_in        = S_EMIT;
            end
         end
         S_EMIT: begin
            // advance one packet per cycle until the last beat
            cmd.step = 1'b1;
            if (stat.step_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/rtp_payload_equal_splitter.sv =====
// Top level: splits a frame payload into about equal RTP packet sizes.
// Status-only results (empty, negative, fit, no capacity) come from the early checks,
// too few and too many from the packet count division; packets follow the per-packet
// division, one per cycle. Both divisions are 22-step serial; a new start is taken only
// when idle. Results are strobed once and cannot be stalled. Synchronous reset restores the
// register defaults and returns the controller to idle. Depends on rpes_pkg.
module rtp_payload_equal_splitter import rpes_pkg::*; #(
   parameter int MAX_PACKETS = DEFAULT_MAX_PACKETS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [PAYLOAD_WIDTH-1:0]   req_payload_size,
   output logic                       rsp_strobe,
   output logic [PAYLOAD_WIDTH-1:0]   rsp_packet_bytes,
   output logic                       rsp_last_packet,
   output logic [2:0]                 rsp_status,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]       csr_write_data
);

   cmd_type  cmd;
   stat_type stat;

   rpes_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   rpes_datapath #(
      .MAX_PACKETS (MAX_PACKETS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_payload_size (req_payload_size),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_packet_bytes (rsp_packet_bytes),
      .rsp_last_packet  (rsp_last_packet),
      .rsp_status       (rsp_status)
   );

endmodule

// ===== tb/rtp_payload_equal_splitter_test.sv =====
// Self-checking testbench for rtp_payload_equal_splitter: directed frame sizes, then random
// frame sizes over several register settings, each beat checked against a table entry or a local model.
// Depends on rpes_pkg and the rtp_payload_equal_splitter RTL.
`timescale 1ns / 100ps

module rtp_payload_equal_splitter_test;
   import rpes_pkg::*;

   typedef struct packed {
      logic [PAYLOAD_WIDTH-1:0] bytes;
      logic                     last;
      status_type               status;
   } packet_beat_type;

   typedef struct {
      bit                       new_settings;
      logic [CFG_WIDTH-1:0]     maxp;
      logic [CFG_WIDTH-1:0]     fr;
      logic [CFG_WIDTH-1:0]     lr;
      logic [CFG_WIDTH-1:0]     sr;
      logic [PAYLOAD_WIDTH-1:0] payload;
      bit                       typed;
      logic [PAYLOAD_WIDTH-1:0] exp_bytes;
      status_type               exp_status;
   } frame_row_type;

   localparam int FRAME_MAX_PACKETS = DEFAULT_MAX_PACKETS;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic [PAYLOAD_WIDTH-1:0]   req_payload_size = '0;
   logic                       rsp_strobe;
   logic [PAYLOAD_WIDTH-1:0]   rsp_packet_bytes;
   logic                       rsp_last_packet;
   logic [2:0]                 rsp_status;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_MAX_PAYLOAD;
   logic [CFG_WIDTH-1:0]       csr_write_data = '0;

   // register copies kept by the predictor
   logic [CFG_WIDTH-1:0] max_payload_cfg      = MAX_PAYLOAD_RESET;
   logic [CFG_WIDTH-1:0] first_reduction_cfg  = FIRST_REDUCTION_RESET;
   logic [CFG_WIDTH-1:0] last_reduction_cfg   = LAST_REDUCTION_RESET;
   logic [CFG_WIDTH-1:0] single_reduction_cfg = SINGLE_REDUCTION_RESET;

   packet_beat_type pending_packets[$];
   int              mismatches  = 0;
   bit              steady_flow = 1'b0;

   frame_row_type directed_rows [25] = '{
      '{0, 16'd1200, 16'd0, 16'd0, 16'd0, 20'd0, 1, 20'd0, ST_EMPTY},
      '{0, 16'd1200, 16'd0, 16'd0, 16'd0, 20'd1, 1, 20'd1, ST_OK},
      '{0, 16'd1200, 16'd0, 16'd0, 16'd0, 20'd1200, 1, 20'd1200, ST_OK},
      '{0, 16'd1200, 16'd0, 16'd0, 16'd0, 20'd1201, 0, 20'd0, ST_OK},
      '{0, 16'd1200, 16'd0, 16'd0, 16'd0, 20'd76800, 0, 20'd0, ST_OK},
      '{0, 16'd1200, 16'd0, 16'd0, 16'd0, 20'd76801, 1, 20'd0, ST_MANY},
      '{0, 16'd1200, 16'd0, 16'd0, 16'd0, 20'hFFFFF, 1, 20'd0, ST_MANY},
      '{1, 16'd100, 16'd30, 16'd20, 16'd10, 20'd90, 1, 20'd90, ST_OK},
      '{0, 16'd100, 16'd30, 16'd20, 16'd10, 20'd91, 0, 20'd0, ST_OK},
      '{0, 16'd100, 16'd30, 16'd20, 16'd10, 20'd437, 0, 20'd0, ST_OK},
      '{1, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 20'd1, 1, 20'd0, ST_FEW},
      '{0, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 20'hFFFFF, 0, 20'd0, ST_OK},
      '{1, 16'd1, 16'd0, 16'd0, 16'd0, 20'd1, 1, 20'd1, ST_OK},
      '{0, 16'd1, 16'd0, 16'd0, 16'd0, 20'd2, 0, 20'd0, ST_OK},
      '{0, 16'd1, 16'd0, 16'd0, 16'd0, 20'd64, 0, 20'd0, ST_OK},
      '{0, 16'd1, 16'd0, 16'd0, 16'd0, 20'd65, 1, 20'd0, ST_MANY},
      '{1, 16'd10, 16'd10, 16'd0, 16'd0, 20'd50, 1, 20'd0, ST_NOCAP},
      '{1, 16'd10, 16'd0, 16'd10, 16'd0, 20'd50, 1, 20'd0, ST_NOCAP},
      '{1, 16'd0, 16'd0, 16'd0, 16'd0, 20'd1, 1, 20'd0, ST_NOCAP},
      '{1, 16'd1200, 16'h8000, 16'd0, 16'd0, 20'd5, 1, 20'd0, ST_NEG},
      '{0, 16'd1200, 16'h8000, 16'd0, 16'd0, 20'd0, 1, 20'd0, ST_EMPTY},
      '{1, 16'd1200, 16'd0, 16'hFFFF, 16'd0, 20'd1, 1, 20'd0, ST_NEG},
      '{1, 16'd10, 16'd9, 16'd9, 16'd0, 20'd30, 0, 20'd0, ST_OK},
      '{0, 16'd10, 16'd9, 16'd9, 16'd0, 20'd11, 0, 20'd0, ST_OK},
      '{1, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'd0, 20'd65536, 0, 20'd0, ST_OK}
   };

   rtp_payload_equal_splitter dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_payload_size (req_payload_size),
      .rsp_strobe       (rsp_strobe),
      .rsp_packet_bytes (rsp_packet_bytes),
      .rsp_last_packet  (rsp_last_packet),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic void expect_beat(input longint bytes, input bit last, input status_type st);
      packet_beat_type beat;
      beat.bytes  = PAYLOAD_WIDTH'(bytes);
      beat.last   = last;
      beat.status = st;
      pending_packets = {pending_packets, beat};
   endfunction

   // Work out the packet sizes for one frame under the current register copies.
   function automatic void split_frame(input logic [PAYLOAD_WIDTH-1:0] size);
      longint payload, maxp, fr, lr, sr;
      longint total, num, per, larger, remaining, left, cur;
      bit     first_pkt;
      payload = longint'(size);
      maxp    = longint'(max_payload_cfg);
      fr      = longint'($signed(first_reduction_cfg));
      lr      = longint'($signed(last_reduction_cfg));
      sr      = longint'(single_reduction_cfg);
      if (payload == 0) begin
         expect_beat(0, 1'b1, ST_EMPTY);
      end else if (fr < 0 || lr < 0) begin
         expect_beat(0, 1'b1, ST_NEG);
      end else if (maxp >= sr + payload) begin
         expect_beat(payload, 1'b1, ST_OK);
      end else if (maxp - fr < 1 || maxp - lr < 1) begin
         expect_beat(0, 1'b1, ST_NOCAP);
      end else begin
         total = payload + fr + lr;
         num   = (total + maxp - 1) / maxp;
         if (num == 1) num = 2;
         if (payload < num) begin
            expect_beat(0, 1'b1, ST_FEW);
         end else if (num > FRAME_MAX_PACKETS) begin
            expect_beat(0, 1'b1, ST_MANY);
         end else begin
            per       = total / num;
            larger    = total % num;
            remaining = payload;
            left      = num;
            first_pkt = 1'b1;
            while (remaining > 0 && left > 0) begin
               // the trailing packets carry the remainder, one byte each
               if (left == larger) per++;
               cur = per;
               if (first_pkt) cur = (cur > fr + 1) ? cur - fr : 1;
               if (cur > remaining) cur = remaining;
               // keep at least one byte for the last packet
               if (left == 2 && cur == remaining) cur--;
               if (left == 1) cur = remaining;
               remaining -= cur;
               left--;
               first_pkt = 1'b0;
               expect_beat(cur, remaining == 0 || left == 0, ST_OK);
            end
         end
      end
   endfunction

   function automatic logic [PAYLOAD_WIDTH-1:0] pick_payload();
      longint cap, n, hi, lo;
      cap = (max_payload_cfg == 0) ? 1 : longint'(max_payload_cfg);
      case ($urandom_range(9))
         0: return PAYLOAD_WIDTH'($urandom_range(20'hFFFFF));
         1: return PAYLOAD_WIDTH'($urandom_range(3));
         2: return PAYLOAD_WIDTH'(cap + longint'($urandom_range(2)) - 1);
         default: begin
            // aim at a chosen packet count, a little past the limit now and then
            n  = longint'($urandom_range(66, 2));
            hi = cap * n;
            lo = cap * (n - 1) + 1;
            if (hi > 20'hFFFFF) hi = 20'hFFFFF;
            if (lo > hi) lo = hi;
            return PAYLOAD_WIDTH'($urandom_range(32'(hi), 32'(lo)));
         end
      endcase
   endfunction

   task automatic csr_beat(input logic [CSR_INDEX_WIDTH-1:0] index,
                           input logic [CFG_WIDTH-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   task automatic write_settings(input logic [CFG_WIDTH-1:0] maxp, fr, lr, sr);
      csr_beat(CSR_MAX_PAYLOAD, maxp);
      csr_beat(CSR_FIRST_REDUCTION, fr);
      csr_beat(CSR_LAST_REDUCTION, lr);
      csr_beat(CSR_SINGLE_REDUCTION, sr);
      csr_write_enable <= 1'b0;
      max_payload_cfg      = maxp;
      first_reduction_cfg  = fr;
      last_reduction_cfg   = lr;
      single_reduction_cfg = sr;
   endtask

   // Drop start and hold until every expected beat is in and the block is idle.
   task automatic settle();
      start <= 1'b0;
      while (pending_packets.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_frame(input logic [PAYLOAD_WIDTH-1:0] size, input bit typed,
                             input logic [PAYLOAD_WIDTH-1:0] typed_bytes,
                             input status_type typed_status);
      while (!steady_flow && $urandom_range(99) < 27) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start            <= 1'b1;
      req_payload_size <= size;
      do @(posedge clock); while (busy);
      if (typed) expect_beat(longint'(typed_bytes), 1'b1, typed_status);
      else split_frame(size);
   endtask

   initial begin
      logic [CFG_WIDTH-1:0] maxp_pick;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].new_settings) begin
            settle();
            write_settings(directed_rows[i].maxp, directed_rows[i].fr,
                           directed_rows[i].lr, directed_rows[i].sr);
         end
         send_frame(directed_rows[i].payload, directed_rows[i].typed,
                    directed_rows[i].exp_bytes, directed_rows[i].exp_status);
      end

      for (int phase = 0; phase < 8; phase++) begin
         settle();
         case ($urandom_range(5))
            0: write_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            1: write_settings(16'd1, 16'd0, 16'd0, 16'($urandom_range(1)));
            2: write_settings(16'hFFFF, 16'h7FFF, 16'($urandom_range(32767)),
                              16'($urandom));
            default: begin
               maxp_pick = 16'($urandom_range(1500, 1));
               write_settings(maxp_pick, 16'($urandom_range(32'(maxp_pick) / 2)),
                              16'($urandom_range(32'(maxp_pick) / 2)),
                              16'($urandom_range(100)));
            end
         endcase
         steady_flow = (phase == 3);
         repeat (40) send_frame(pick_payload(), 1'b0, '0, ST_OK);
      end

      settle();
      repeat (60) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   always @(posedge clock) begin
      packet_beat_type seen;
      seen.bytes  = rsp_packet_bytes;
      seen.last   = rsp_last_packet;
      seen.status = status_type'(rsp_status);
      if (!reset && rsp_strobe) begin
         if (pending_packets.size() == 0) begin
            $display("%0t: unexpected beat: bytes=%0d last=%0b status=%0d",
                     $time, seen.bytes, seen.last, seen.status);
            mismatches++;
         end else begin
            if (pending_packets[0] !== seen) begin
               $display("%0t: mismatch: expected bytes=%0d last=%0b status=%0d",
                        $time, pending_packets[0].bytes, pending_packets[0].last,
                        pending_packets[0].status);
               $display("%0t:           actual   bytes=%0d last=%0b status=%0d",
                        $time, seen.bytes, seen.last, seen.status);
               mismatches++;
            end
            void'(pending_packets.pop_front());
         end
      end
   end

endmodule

// ===== rtp_payload_equal_splitter.f =====
rtl/core/rpes_pkg.sv
rtl/core/rpes_divider.sv
rtl/core/rpes_datapath.sv
rtl/core/rpes_ctrl.sv
rtl/core/rtp_payload_equal_splitter.sv
tb/rtp_payload_equal_splitter_test.sv
